// ===== hw/rtl/state_priority_message_classifier_macros.svh =====
// Assertion macros used by the classifier top level.
// Needs no other file; included by the top level, the one module that carries assertions.
`ifndef STATE_PRIORITY_MESSAGE_CLASSIFIER_MACROS_SVH
`define STATE_PRIORITY_MESSAGE_CLASSIFIER_MACROS_SVH

// Condition that must hold whenever the trigger holds, in the same cycle.
`define SPMC_ASSERT_IMPL(label, clock, reset, trig, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define SPMC_ASSERT_NEXT(label, clock, reset, trig, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/spmc_pkg.sv =====
// Types, pattern tables and reset state for the priority message classifier.
// Has no dependencies; imported by spmc_step, the top level and the testbench.
package spmc_pkg;

  localparam int unsigned KEY_LEN   = 7;
  localparam int unsigned NEEDS_LEN = 10;
  localparam int unsigned ERROR_LEN = 6;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_AFTER_KEY   = 2'd1,
    PH_AFTER_COLON = 2'd2,
    PH_VALUE       = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0] key_progress;
    phase_t     phase;
    logic [3:0] value_progress;
    logic       needs_alive;
    logic       error_alive;
    logic       found;
  } spmc_state_t;

  localparam spmc_state_t STATE_RESET = '{
    key_progress:   3'd0,
    phase:          PH_IDLE,
    value_progress: 4'd0,
    needs_alive:    1'b0,
    error_alive:    1'b0,
    found:          1'b0
  };

  // The quoted key "state", quotes included.
  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_QUOTE;
      3'd1:    c = 8'h73;  // s
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h74;  // t
      3'd5:    c = 8'h65;  // e
      3'd6:    c = CHAR_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // The needs_you value with its closing quote.
  function automatic logic [7:0] needs_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6e;  // n
      4'd1:    c = 8'h65;  // e
      4'd2:    c = 8'h65;  // e
      4'd3:    c = 8'h64;  // d
      4'd4:    c = 8'h73;  // s
      4'd5:    c = 8'h5f;  // _
      4'd6:    c = 8'h79;  // y
      4'd7:    c = 8'h6f;  // o
      4'd8:    c = 8'h75;  // u
      4'd9:    c = CHAR_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // The value error with its closing quote.
  function automatic logic [7:0] error_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h65;  // e
      4'd1:    c = 8'h72;  // r
      4'd2:    c = 8'h72;  // r
      4'd3:    c = 8'h6f;  // o
      4'd4:    c = 8'h72;  // r
      4'd5:    c = CHAR_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

endpackage

// ===== hw/rtl/spmc_step.sv =====
// Next-state logic of the classifier: one byte advances the key tracker,
// the post-key phase tracker and the sticky found flag. Uses spmc_pkg.
module spmc_step
  import spmc_pkg::*;
(
  input  spmc_state_t cur,
  input  logic [7:0]  byte_value,
  output spmc_state_t nxt
);

  spmc_state_t ph;
  logic        needs_ok;
  logic        error_ok;
  logic        hit;
  logic        key_ok;

  // Value candidates: each survives only while its byte matches.
  assign needs_ok = cur.needs_alive && (cur.value_progress < 4'(NEEDS_LEN)) &&
                    (byte_value == needs_char(cur.value_progress));
  assign error_ok = cur.error_alive && (cur.value_progress < 4'(ERROR_LEN)) &&
                    (byte_value == error_char(cur.value_progress));
  assign hit = (needs_ok && (cur.value_progress == 4'(NEEDS_LEN - 1))) ||
               (error_ok && (cur.value_progress == 4'(ERROR_LEN - 1)));

  // Phase tracker runs first on the current byte.
  always_comb begin
    ph = cur;
    case (cur.phase)
      PH_AFTER_KEY: begin
        if (byte_value == CHAR_COLON) begin
          ph.phase = PH_AFTER_COLON;
        end else if (!is_space(byte_value)) begin
          ph.phase          = PH_IDLE;
          ph.value_progress = 4'd0;
          ph.needs_alive    = 1'b0;
          ph.error_alive    = 1'b0;
        end
      end
      PH_AFTER_COLON: begin
        if (byte_value == CHAR_QUOTE) begin
          ph.phase          = PH_VALUE;
          ph.value_progress = 4'd0;
          ph.needs_alive    = 1'b1;
          ph.error_alive    = 1'b1;
        end else if (!is_space(byte_value)) begin
          ph.phase          = PH_IDLE;
          ph.value_progress = 4'd0;
          ph.needs_alive    = 1'b0;
          ph.error_alive    = 1'b0;
        end
      end
      PH_VALUE: begin
        if (hit || (!needs_ok && !error_ok)) begin
          ph.phase          = PH_IDLE;
          ph.value_progress = 4'd0;
          ph.needs_alive    = 1'b0;
          ph.error_alive    = 1'b0;
          ph.found          = cur.found | hit;
        end else begin
          ph.needs_alive    = needs_ok;
          ph.error_alive    = error_ok;
          ph.value_progress = cur.value_progress + 4'd1;
        end
      end
      default: begin
        ph.phase          = PH_IDLE;
        ph.value_progress = 4'd0;
        ph.needs_alive    = 1'b0;
        ph.error_alive    = 1'b0;
      end
    endcase
  end

  assign key_ok = (cur.key_progress < 3'(KEY_LEN)) &&
                  (byte_value == key_char(cur.key_progress));

  // Key tracker; a completed key restarts the phase tracker after the key.
  // Its closing quote also opens the next key candidate.
  always_comb begin
    nxt = ph;
    if (key_ok) begin
      if (cur.key_progress == 3'(KEY_LEN - 1)) begin
        nxt.key_progress   = 3'd1;
        nxt.phase          = PH_AFTER_KEY;
        nxt.value_progress = 4'd0;
        nxt.needs_alive    = 1'b0;
        nxt.error_alive    = 1'b0;
      end else begin
        nxt.key_progress = cur.key_progress + 3'd1;
      end
    end else begin
      nxt.key_progress = (byte_value == CHAR_QUOTE) ? 3'd1 : 3'd0;
    end
  end

endmodule

// ===== hw/rtl/state_priority_message_classifier.sv =====
// Top level of the priority message classifier: input handshake, tracker
// state, result register. Uses spmc_pkg, spmc_step and the macros header.
//
// Usage:
//   Message bytes enter on the s_ channel, one word per byte, with s_tlast
//   high on the final byte. Bytes that are not final yield no result. The
//   final byte yields one result word on the m_ channel: m_tdata[0] is 1 when
//   the message held the key "state" followed by a colon and the quoted value
//   needs_you or error (whitespace allowed around the colon).
//   Throughput: one byte per cycle while no result waits undrained; all per-byte
//   work is one pass of next-state logic into the tracker registers.
//   Latency: the result is valid in the cycle after its final byte is taken.
//   Stalls: a single result register holds a pending result; s_tready stays
//   high while that register is empty or is being drained in the same cycle,
//   so a new byte is taken even as the previous result is handed over.
//   Reset (rst, synchronous) clears all trackers and drops any pending result.
//   All trackers also clear after every final byte.
`include "state_priority_message_classifier_macros.svh"

module state_priority_message_classifier
  import spmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] is_priority, [7:1] zero
);

  spmc_state_t state;
  spmc_state_t state_next;
  logic        is_priority;
  logic        s_accept;
  logic        last_accept;
  logic        state_clear;
  logic        value_live;
  logic        value_quiet;

  spmc_step u_step (
    .cur        (state),
    .byte_value (s_tdata),
    .nxt        (state_next)
  );

  assign s_tready    = !m_tvalid || m_tready;
  assign s_accept    = s_tvalid && s_tready;
  assign last_accept = s_accept && s_tlast;
  assign m_tdata     = {7'd0, is_priority};

  // Tracker state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= STATE_RESET;
      m_tvalid    <= 1'b0;
      is_priority <= 1'b0;
    end else begin
      if (last_accept) begin
        state       <= STATE_RESET;
        m_tvalid    <= 1'b1;
        is_priority <= state_next.found;
      end else begin
        if (s_accept) begin
          state <= state_next;
        end
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  // Conditions watched by the assertions.
  assign state_clear = (state.key_progress == 3'd0) && (state.phase == PH_IDLE) &&
                       !state.found;
  assign value_live  = (state.needs_alive || state.error_alive) &&
                       (state.value_progress < 4'(NEEDS_LEN));
  assign value_quiet = !state.needs_alive && !state.error_alive &&
                       (state.value_progress == 4'd0);

  `SPMC_ASSERT_NEXT(a_last_gives_result, clk, rst, last_accept, m_tvalid, "missing result")
  `SPMC_ASSERT_NEXT(a_last_clears, clk, rst, last_accept, state_clear, "trackers not cleared")
  `SPMC_ASSERT_IMPL(a_key_range, clk, rst, 1'b1, state.key_progress < 3'(KEY_LEN), "key range")
  `SPMC_ASSERT_IMPL(a_value_live, clk, rst, state.phase == PH_VALUE, value_live, "value idle")
  `SPMC_ASSERT_IMPL(a_no_value_outside, clk, rst, state.phase != PH_VALUE, value_quiet, "value busy")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the priority message classifier.
// Drives byte streams into state_priority_message_classifier and checks each
// flag word against a scanner model kept here; needs spmc_pkg and the RTL.
`timescale 1ns / 1ps

module tb
  import spmc_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned PHASE_BYTES    = 330;
  localparam string       KEY_TEXT       = "\"state\"";
  localparam string       NEEDS_TEXT     = {"needs", "_you", "\""};
  localparam string       ERROR_TEXT     = "error\"";

  // Scanner model of the classifier plus the flags it still owes.
  class priority_scanner;
    logic [2:0] key_pos;
    phase_t     ph;
    logic [3:0] val_pos;
    bit         needs_ok;
    bit         error_ok;
    bit         seen;
    bit         pending_flags[$];
    int unsigned errors;
    string      key_str   = "\"state\"";
    string      needs_str = {"needs", "_you", "\""};
    string      error_str = "error\"";

    function new();
      errors = 0;
      clear();
    endfunction

    function void drop_value();
      ph       = PH_IDLE;
      val_pos  = 4'd0;
      needs_ok = 1'b0;
      error_ok = 1'b0;
    endfunction

    function void clear();
      key_pos = 3'd0;
      seen    = 1'b0;
      drop_value();
    endfunction

    function bit blank(logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

    // Tracker that follows the colon and the quoted value after a key.
    function void advance_phase(logic [7:0] b);
      bit hit;
      hit = 1'b0;
      case (ph)
        PH_AFTER_KEY: begin
          if (b == CHAR_COLON) ph = PH_AFTER_COLON;
          else if (!blank(b)) drop_value();
        end
        PH_AFTER_COLON: begin
          if (b == CHAR_QUOTE) begin
            ph       = PH_VALUE;
            val_pos  = 4'd0;
            needs_ok = 1'b1;
            error_ok = 1'b1;
          end else if (!blank(b)) begin
            drop_value();
          end
        end
        PH_VALUE: begin
          if (needs_ok) begin
            if (val_pos < needs_str.len() && b == needs_str[val_pos]) begin
              if (val_pos == needs_str.len() - 1) hit = 1'b1;
            end else begin
              needs_ok = 1'b0;
            end
          end
          if (error_ok) begin
            if (val_pos < error_str.len() && b == error_str[val_pos]) begin
              if (val_pos == error_str.len() - 1) hit = 1'b1;
            end else begin
              error_ok = 1'b0;
            end
          end
          if (hit) begin
            seen = 1'b1;
            drop_value();
          end else if (!needs_ok && !error_ok) begin
            drop_value();
          end else begin
            val_pos = val_pos + 4'd1;
          end
        end
        default: drop_value();
      endcase
    endfunction

    // Key tracker; the closing quote of a full key also opens the next one.
    function void advance_key(logic [7:0] b);
      if (key_pos < key_str.len() && b == key_str[key_pos]) begin
        if (key_pos == key_str.len() - 1) begin
          key_pos = 3'd1;
          drop_value();
          ph = PH_AFTER_KEY;
        end else begin
          key_pos = key_pos + 3'd1;
        end
      end else begin
        key_pos = (b == CHAR_QUOTE) ? 3'd1 : 3'd0;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      advance_phase(b);
      advance_key(b);
      if (last) begin
        pending_flags.push_back(seen);
        clear();
      end
    endfunction

    function void check_flag(logic [7:0] got);
      logic [7:0] want;
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected flag word, got %h", $time, got);
        errors++;
      end else begin
        want = {7'd0, pending_flags.pop_front()};
        if (got !== want) begin
          $display("%0t: flag word mismatch, expected %h, got %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_flags.size();
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  priority_scanner sb = new();
  logic [7:0]  msg_bytes[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_by_phase[4]  = '{0, 68, 0, 34};
  int unsigned recv_stall_by_phase[4] = '{0, 0, 68, 34};

  state_priority_message_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Watch both channels; a result is checked before the same edge's byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_flag(m_tdata);
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
    end
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("state_priority_message_classifier test failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void put_blanks();
    repeat ($urandom_range(0, 2)) msg_bytes.push_back(blank_char());
  endfunction

  // One of the two values, sometimes with a bad byte or cut short.
  function automatic void put_value();
    string       v;
    int unsigned mode;
    int unsigned bad_pos;
    int unsigned keep;
    if ($urandom_range(0, 1) != 0) v = NEEDS_TEXT;
    else v = ERROR_TEXT;
    mode    = $urandom_range(0, 5);
    bad_pos = $urandom_range(0, v.len() - 1);
    keep    = (mode == 2) ? $urandom_range(1, v.len() - 1) : v.len();
    for (int i = 0; i < keep; i++) begin
      if (mode == 1 && i == bad_pos) msg_bytes.push_back(8'($urandom_range(0, 255)));
      else msg_bytes.push_back(v[i]);
    end
  endfunction

  // Well-formed key/value runs half the time, mixed with partial keys, bare values and noise.
  function automatic void build_message();
    msg_bytes.delete();
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          put_text(KEY_TEXT);
          put_blanks();
          msg_bytes.push_back(CHAR_COLON);
          put_blanks();
          msg_bytes.push_back(CHAR_QUOTE);
          put_value();
        end
        4: begin
          // Chained keys share their quotes.
          put_text(KEY_TEXT);
          repeat ($urandom_range(1, 2)) put_text("state\"");
          msg_bytes.push_back(CHAR_COLON);
          msg_bytes.push_back(CHAR_QUOTE);
          put_value();
        end
        5: repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        6: begin
          case ($urandom_range(0, 2))
            0:       msg_bytes.push_back(CHAR_QUOTE);
            1:       msg_bytes.push_back(CHAR_COLON);
            default: msg_bytes.push_back(blank_char());
          endcase
        end
        7: put_text(KEY_TEXT.substr(0, $urandom_range(0, 5)));
        8: begin
          msg_bytes.push_back(CHAR_QUOTE);
          put_value();
        end
        default: begin
          put_text(KEY_TEXT);
          put_blanks();
          msg_bytes.push_back(CHAR_COLON);
          msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // Cut some messages off at a random point.
    if ($urandom_range(0, 3) == 0) begin
      int unsigned keep;
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Stop sending and wait until every owed flag word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_bytes;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-byte messages at both byte extremes, then a plain error match.
    msg_bytes.delete();
    msg_bytes.push_back(8'h00);
    send_message();
    msg_bytes.delete();
    msg_bytes.push_back(8'hff);
    send_message();
    msg_bytes.delete();
    put_text("\"state\":\"error\"");
    send_message();
    drain();

    // Random messages under each idling mix.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      phase_bytes    = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_message();
        send_message();
        phase_bytes += msg_bytes.size();
      end
      drain();
    end

    // Long result hold-off while short messages keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    repeat (12) begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      send_message();
    end
    while (hold_off_req) @(posedge clk);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("state_priority_message_classifier test passed");
    end else begin
      $display("state_priority_message_classifier test failed");
    end
    $finish;
  end

endmodule

// ===== state_priority_message_classifier.f =====
+incdir+hw/rtl
hw/rtl/spmc_pkg.sv
hw/rtl/spmc_step.sv
hw/rtl/state_priority_message_classifier.sv
tb/tb.sv
